@@ hdl/fqs_pkg.sv @@
// Shared constants, codes and types for the FIFO queue with sort unit.
package fqs_pkg;

    localparam int DEPTH  = 64;
    localparam int WORD_W = 32;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam int S_DATA_W = 32;   // push_value
    localparam int S_USER_W = 2;    // op
    localparam int M_DATA_W = 48;   // head_value, head_valid, entry_count, error_code

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [CNT_W-1:0]         count_t;
    typedef logic [1:0]               op_t;
    typedef logic [1:0]               err_t;
    typedef logic [2:0]               cell_sel_t;

    // commands
    localparam op_t OP_PUSH   = 2'd0;
    localparam op_t OP_POP    = 2'd1;
    localparam op_t OP_ROTATE = 2'd2;
    localparam op_t OP_SORT   = 2'd3;

    // error codes
    localparam err_t ERR_NONE  = 2'd0;
    localparam err_t ERR_EMPTY = 2'd1;
    localparam err_t ERR_FULL  = 2'd2;

    // cell load selects
    localparam cell_sel_t SEL_HOLD  = 3'd0;
    localparam cell_sel_t SEL_PUSH  = 3'd1;
    localparam cell_sel_t SEL_RIGHT = 3'd2;
    localparam cell_sel_t SEL_LEFT  = 3'd3;
    localparam cell_sel_t SEL_HEAD  = 3'd4;

endpackage

@@ hdl/fqs_cell.sv @@
// One storage cell of the queue chain with its neighbor compare.
module fqs_cell
    import fqs_pkg::*;
(
    input  logic      aclk,
    input  cell_sel_t sel,
    input  word_t     push_word,
    input  word_t     left_word,
    input  word_t     right_word,
    input  word_t     head_word,
    output word_t     word_q,
    output word_t     word_d,
    output logic      gt_right
);

    word_t word_reg;
    word_t word_next;

    always_comb begin
        case (sel)
            SEL_HOLD:  word_next = word_reg;
            SEL_PUSH:  word_next = push_word;
            SEL_RIGHT: word_next = right_word;
            SEL_LEFT:  word_next = left_word;
            SEL_HEAD:  word_next = head_word;
            default:   word_next = word_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    // strict compare keeps equal words in order during the sort
    assign gt_right = word_reg > right_word;
    assign word_q   = word_reg;
    assign word_d   = word_next;

endmodule

@@ hdl/fifo_queue_with_sort_unit.sv @@
// Top level: bounded FIFO kept in a chain of cells, with odd-even transposition sort.
//
// Input stream (s_*): s_tuser carries the command (push, pop, move head to tail,
// sort ascending), s_tdata carries the signed word used by a push.
// Result stream (m_*): one word per command with the head word, a head valid
// flag, the entry count and an error code (pop on empty, push on full).
// The head of the queue always sits in cell 0; pop shifts the whole chain and
// rotate the occupied cells one cell toward the head, rotate moving the head
// to the tail; push writes the cell at the tail position.
// Push, pop and rotate: result registered at the accepting edge, seen in the
// next cycle; one command per cycle while m_tready stays high.
// Sort: one compare-exchange phase per cycle, alternating between even and odd
// neighbor pairs, as many phases as words held; the result is registered with
// the last phase (at accept for a queue of fewer than two words). No command
// is taken while the sort runs.
// s_tready is low while a result waits and m_tready is low; the held result
// stays stable until taken.
// Reset empties the queue and drops any pending result; cell contents are
// not cleared.
module fifo_queue_with_sort_unit
    import fqs_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [31:0] push_value
    input  logic [S_USER_W-1:0] s_tuser,   // [1:0] op
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // [31:0] head_value, [32] head_valid,
                                           // [39:33] entry_count, [41:40] error_code
);

    localparam count_t DEPTH_C = CNT_W'(DEPTH);
    localparam count_t ONE_C   = CNT_W'(1);

    word_t     cell_q [DEPTH];
    word_t     cell_d [DEPTH];
    cell_sel_t sel    [DEPTH];
    logic      gt     [DEPTH];

    count_t count_reg, count_next;
    count_t phase_reg, phase_next;
    logic   busy_reg, busy_next;

    logic   m_tvalid_reg, m_tvalid_next;
    word_t  head_reg;
    logic   valid_reg;
    count_t cnt_out_reg;
    err_t   err_reg;

    logic   accept;
    op_t    op;
    word_t  push_word;
    logic   sort_last;
    logic   load_out;
    err_t   err_now;

    assign op        = s_tuser[1:0];
    assign push_word = s_tdata[WORD_W-1:0];
    assign s_tready  = !busy_reg && (!m_tvalid_reg || m_tready);
    assign accept    = s_tvalid && s_tready;
    assign sort_last = busy_reg && (phase_reg == count_reg - ONE_C);

    // cell chain and per-cell load selects
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        localparam count_t IDX_C = CNT_W'(i);
        word_t left_w;
        word_t right_w;
        logic  take_right_swap;
        logic  take_left_swap;

        if (i == 0) begin : g_first
            assign left_w         = '0;
            assign take_left_swap = 1'b0;
        end else begin : g_mid
            assign left_w         = cell_q[i-1];
            assign take_left_swap = (IDX_C[0] != phase_reg[0]) && (IDX_C < count_reg)
                                    && gt[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_w = '0;
        end else begin : g_inner
            assign right_w = cell_q[i+1];
        end

        assign take_right_swap = (IDX_C[0] == phase_reg[0]) && (IDX_C + ONE_C < count_reg)
                                 && gt[i];

        always_comb begin
            sel[i] = SEL_HOLD;
            if (busy_reg) begin
                if (take_right_swap) begin
                    sel[i] = SEL_RIGHT;
                end else if (take_left_swap) begin
                    sel[i] = SEL_LEFT;
                end
            end else if (accept) begin
                case (op)
                    OP_PUSH: begin
                        if (count_reg != DEPTH_C && IDX_C == count_reg) begin
                            sel[i] = SEL_PUSH;
                        end
                    end
                    OP_POP: begin
                        if (count_reg != '0) begin
                            sel[i] = SEL_RIGHT;
                        end
                    end
                    OP_ROTATE: begin
                        if (count_reg != '0) begin
                            if (IDX_C == count_reg - ONE_C) begin
                                sel[i] = SEL_HEAD;
                            end else if (IDX_C < count_reg) begin
                                sel[i] = SEL_RIGHT;
                            end
                        end
                    end
                    default: sel[i] = SEL_HOLD;
                endcase
            end
        end

        fqs_cell u_cell (
            .aclk       (aclk),
            .sel        (sel[i]),
            .push_word  (push_word),
            .left_word  (left_w),
            .right_word (right_w),
            .head_word  (cell_q[0]),
            .word_q     (cell_q[i]),
            .word_d     (cell_d[i]),
            .gt_right   (gt[i])
        );
    end

    always_comb begin
        count_next = count_reg;
        phase_next = phase_reg;
        busy_next  = busy_reg;
        err_now    = ERR_NONE;
        load_out   = 1'b0;
        if (busy_reg) begin
            phase_next = phase_reg + ONE_C;
            if (sort_last) begin
                busy_next = 1'b0;
                load_out  = 1'b1;
            end
        end else if (accept) begin
            case (op)
                OP_PUSH: begin
                    load_out = 1'b1;
                    if (count_reg == DEPTH_C) begin
                        err_now = ERR_FULL;
                    end else begin
                        count_next = count_reg + ONE_C;
                    end
                end
                OP_POP: begin
                    load_out = 1'b1;
                    if (count_reg == '0) begin
                        err_now = ERR_EMPTY;
                    end else begin
                        count_next = count_reg - ONE_C;
                    end
                end
                OP_ROTATE: begin
                    load_out = 1'b1;
                end
                OP_SORT: begin
                    if (count_reg < CNT_W'(2)) begin
                        load_out = 1'b1;
                    end else begin
                        busy_next  = 1'b1;
                        phase_next = '0;
                    end
                end
                default: load_out = 1'b0;
            endcase
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            phase_reg    <= '0;
            busy_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            phase_reg    <= phase_next;
            busy_reg     <= busy_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            head_reg    <= (count_next != '0) ? cell_d[0] : '0;
            valid_reg   <= (count_next != '0);
            cnt_out_reg <= count_next;
            err_reg     <= err_now;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, err_reg, cnt_out_reg, valid_reg, head_reg};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("entry count above depth");

    a_sort_min: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> count_reg >= CNT_W'(2))
        else $error("sort running on fewer than two words");

    a_sort_report: assert property (@(posedge aclk) disable iff (!aresetn)
        sort_last |=> m_tvalid_reg && err_reg == ERR_NONE)
        else $error("sort finished without a result word");

    a_valid_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> valid_reg == (cnt_out_reg != '0))
        else $error("head valid does not match count");

    a_full_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && err_reg == ERR_FULL |-> cnt_out_reg == DEPTH_C)
        else $error("full error reported on a queue that is not full");
`endif

endmodule
